>>> rtl/core/fbsg_pkg.sv
// Package for the block-scaled FP4 matrix-vector unit: item types, sizes and decoders.
// Has no dependencies; fbsg_mac and the top level use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package fbsg_pkg;

  localparam int ActDepth = 4096;
  localparam int ActAw = $clog2(ActDepth);
  localparam int BlkLen = 16;
  localparam int MaxBlocks = 256;

  // Input item kinds.
  localparam logic KIND_ACT = 1'b0;
  localparam logic KIND_WGT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [11:0] act_index;
    logic signed [15:0] act_value;
    logic [63:0] packed_weights;
    logic [7:0]  scale_code;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] row_sum;
    logic [15:0]        row_number;
  } out_item_t;

  // E2M1 code to a signed value in halves.
  function automatic logic signed [4:0] e2m1_halves(input logic [3:0] c);
    logic [3:0] mag;
    begin
      case (c[2:0])
        3'd0: mag = 4'd0;
        3'd1: mag = 4'd1;
        3'd2: mag = 4'd2;
        3'd3: mag = 4'd3;
        3'd4: mag = 4'd4;
        3'd5: mag = 4'd6;
        3'd6: mag = 4'd8;
        default: mag = 4'd12;
      endcase
      e2m1_halves = c[3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  endfunction

  // E4M3 scale to a signed integer in units of 2^-9 (exponent 15 is normal).
  function automatic logic signed [18:0] e4m3_units(input logic [7:0] code);
    logic [17:0] mag;
    begin
      if (code[6:3] == 4'd0) mag = {15'd0, code[2:0]};
      else mag = 18'({1'b1, code[2:0]}) << (code[6:3] - 4'd1);
      e4m3_units = code[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/fbsg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fbsg_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(Depth)-1:0]  waddr,
  input  wire [Width-1:0]          wdata,
  input  wire [$clog2(Depth)-1:0]  raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/fbsg_mac.sv
// Dot-product engine: one activation times one decoded weight per cycle while acc_en is high, then scale.
// Uses fbsg_pkg for the weight and scale decoders.
`timescale 1ns / 1ps
`default_nettype none
module fbsg_mac (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               clr,       // start of a new block
  input  wire               acc_en,    // activation data valid this cycle
  input  wire [3:0]         nib,
  input  wire signed [15:0] act,
  input  wire               scale_en,  // multiply the finished dot by the scale
  input  wire [7:0]         scale_code,
  output logic signed [44:0] prod_r
);
  logic signed [25:0] dot_r, dot_nxt;
  logic signed [20:0] term;
  logic signed [44:0] prod_nxt;

  // Product of one weight and one activation, 21 bits signed.
  assign term = 21'(fbsg_pkg::e2m1_halves(nib)) * 21'(act);

  always_comb begin
    dot_nxt = clr ? 26'sd0 : dot_r;
    if (acc_en) dot_nxt = dot_nxt + 26'(term);
    prod_nxt = prod_r;
    if (scale_en) prod_nxt = 45'(dot_r) * 45'(fbsg_pkg::e4m3_units(scale_code));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      prod_r <= '0;
    end else begin
      dot_r <= dot_nxt;
      prod_r <= prod_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/fp4_block_scaled_gemv_top.sv
// Top level of the block-scaled FP4 matrix-vector unit; uses fbsg_pkg, fbsg_ram, fbsg_mac.
// An activation item is written to the RAM as it is accepted; the unit stays ready. A weight item
// runs through the read state (16 reads of the activation RAM with its registered read data),
// one scale multiply and one accumulate, which registers a finished row's result; no item is taken meanwhile.
// A waiting result stalls only a row-ending block, in its accumulate cycle.
// Reset (rst_n low, synchronous) clears row state, sets blocks_per_row to 160; RAM kept.
`timescale 1ns / 1ps
`default_nettype none
module fp4_block_scaled_gemv_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire fbsg_pkg::in_item_t in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output fbsg_pkg::out_item_t out_item,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [8:0]           cfg_data
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_ACC = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;      // read index, 0..16
  logic        rd_vld_r;            // RAM data valid this cycle
  logic [3:0]  rd_idx_r;            // weight index matching RAM data
  logic [63:0] wts_r;
  logic [7:0]  scl_r;
  logic [7:0]  blk_r, blk_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic [15:0] rows_r, rows_nxt;
  logic [8:0]  bpr_r;
  logic        out_valid_r, out_valid_nxt;
  fbsg_pkg::out_item_t out_r, out_nxt;
  logic        accept, we;
  logic [fbsg_pkg::ActAw-1:0] raddr;
  logic [15:0] rdata;
  logic signed [44:0] prod;
  logic [8:0]  nblk;
  logic        row_end;

  assign in_ready = (state_r == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item = out_r;

  // Activation writes; out-of-range indexes cannot occur at this depth.
  assign we = accept && (in_item.kind == fbsg_pkg::KIND_ACT);
  assign raddr = fbsg_pkg::ActAw'({blk_r, cnt_r[3:0]});

  fbsg_ram #(.Width(16), .Depth(fbsg_pkg::ActDepth)) u_act (
    .clk(clk), .we(we), .waddr(fbsg_pkg::ActAw'(in_item.act_index)),
    .wdata(in_item.act_value), .raddr(raddr), .rdata(rdata)
  );

  fbsg_mac u_mac (
    .clk(clk), .rst_n(rst_n),
    .clr(state_r == ST_IDLE), .acc_en(rd_vld_r),
    .nib(wts_r[4*rd_idx_r +: 4]), .act(rdata),
    .scale_en(state_r == ST_SCALE), .scale_code(scl_r),
    .prod_r(prod)
  );

  // Effective row length, clamped to 1..256.
  assign nblk = (bpr_r == 9'd0) ? 9'd1 : (bpr_r > 9'd256) ? 9'd256 : bpr_r;
  assign row_end = ({1'b0, blk_r} + 9'd1) >= nblk;

  // Sequencer and row accumulation.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    blk_nxt = blk_r;
    acc_nxt = acc_r;
    rows_nxt = rows_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && in_item.kind == fbsg_pkg::KIND_WGT) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (cnt_r == 5'd16) begin
          cnt_nxt = '0;
          state_nxt = ST_SCALE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_SCALE: state_nxt = ST_ACC;
      ST_ACC: begin
        if (row_end) begin
          // A row-ending block waits here while the previous result is unread.
          if (!out_valid_r || out_ready) begin
            state_nxt = ST_IDLE;
            rows_nxt = rows_r + 16'd1;
            out_nxt.row_sum = acc_r + 64'(prod);
            out_nxt.row_number = rows_nxt;
            out_valid_nxt = 1'b1;
            acc_nxt = '0;
            blk_nxt = '0;
          end
        end else begin
          state_nxt = ST_IDLE;
          acc_nxt = acc_r + 64'(prod);
          blk_nxt = blk_r + 8'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      rd_vld_r <= 1'b0;
      blk_r <= '0;
      acc_r <= '0;
      rows_r <= '0;
      bpr_r <= 9'd160;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      rd_vld_r <= (state_r == ST_READ) && (cnt_r < 5'd16);
      blk_r <= blk_nxt;
      acc_r <= acc_nxt;
      rows_r <= rows_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) bpr_r <= cfg_data;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[3:0];
    out_r <= out_nxt;
    if (accept) begin
      wts_r <= in_item.packed_weights;
      scl_r <= in_item.scale_code;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("result dropped");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'd16) else $error("read counter out of range");
`endif
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the block-scaled FP4 matrix-vector unit.
// Depends on fbsg_pkg and fp4_block_scaled_gemv_top; it predicts every row sum on its own.
`timescale 1ns / 1ps
module testbench;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 40;
  // The directed tests write only the first FillDepth activations, and rows stay within FillBlocks.
  localparam int FillDepth = 1024;
  localparam int FillBlocks = FillDepth / fbsg_pkg::BlkLen;
  localparam int RandomItems = 600;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  fbsg_pkg::in_item_t in_item;
  logic out_valid;
  logic out_ready;
  fbsg_pkg::out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [8:0] cfg_data;

  fp4_block_scaled_gemv_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the unit's state.
  logic signed [15:0] act_mem [fbsg_pkg::ActDepth];
  int unsigned blk_pos;
  longint row_acc;
  logic [15:0] rows_done;
  logic [8:0] row_len_reg;
  fbsg_pkg::out_item_t pending_rows[$];
  int errors;
  int items_sent;
  int rows_checked;
  int burst_left;
  int idle_cycles;

  // E2M1 magnitudes in halves, indexed by the low three code bits.
  function automatic int weight_halves(input logic [3:0] c);
    int lut [8];
    lut = '{0, 1, 2, 3, 4, 6, 8, 12};
    return c[3] ? -lut[c[2:0]] : lut[c[2:0]];
  endfunction

  // E4M3 scale as an integer count of 2^-9.
  function automatic longint scale_in_units(input logic [7:0] code);
    longint mag;
    if (code[6:3] == 4'd0) mag = longint'(code[2:0]);
    else mag = longint'(8 + code[2:0]) <<< (code[6:3] - 1);
    return code[7] ? -mag : mag;
  endfunction

  // Updates the shadow state for one accepted item and queues any finished row.
  task automatic predict_row(input fbsg_pkg::in_item_t it);
    longint dot;
    int unsigned eff_len;
    fbsg_pkg::out_item_t row;
    if (it.kind == fbsg_pkg::KIND_ACT) begin
      act_mem[it.act_index] = it.act_value;
    end else begin
      dot = 0;
      for (int i = 0; i < fbsg_pkg::BlkLen; i++) begin
        dot += longint'(weight_halves(it.packed_weights[4*i +: 4])) *
               longint'(act_mem[(blk_pos * fbsg_pkg::BlkLen + i) % fbsg_pkg::ActDepth]);
      end
      row_acc += dot * scale_in_units(it.scale_code);
      eff_len = (row_len_reg == 0) ? 1 :
                (row_len_reg > fbsg_pkg::MaxBlocks ? fbsg_pkg::MaxBlocks : row_len_reg);
      if (blk_pos + 1 >= eff_len) begin
        rows_done = rows_done + 16'd1;
        row.row_sum = row_acc;
        row.row_number = rows_done;
        pending_rows.push_back(row);
        row_acc = 0;
        blk_pos = 0;
      end else begin
        blk_pos = (blk_pos + 1) & 8'hFF;
      end
    end
  endtask

  function automatic fbsg_pkg::in_item_t act_item(input logic [11:0] idx,
                                                  input logic [15:0] val);
    fbsg_pkg::in_item_t it;
    it.kind = fbsg_pkg::KIND_ACT;
    it.act_index = idx;
    it.act_value = val;
    it.packed_weights = {$urandom, $urandom};
    it.scale_code = 8'($urandom);
    return it;
  endfunction

  function automatic fbsg_pkg::in_item_t weight_item(input logic [63:0] w,
                                                     input logic [7:0] sc);
    fbsg_pkg::in_item_t it;
    it.kind = fbsg_pkg::KIND_WGT;
    it.act_index = 12'($urandom);
    it.act_value = 16'($urandom);
    it.packed_weights = w;
    it.scale_code = sc;
    return it;
  endfunction

  // Sends one item; the sender runs in bursts separated by random gaps.
  task automatic send_item(input fbsg_pkg::in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    predict_row(it);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Lowers valid, waits for all rows, then lets an in-flight block finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_row_len(input logic [8:0] len);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    row_len_reg = len;
  endtask

  function automatic logic [15:0] rand_act();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_weights();
    return {$urandom, $urandom};
  endfunction

  // Fills the activations in use; the reset row length of 160 must not end a row early,
  // and shortening it to 61 ends the open row at its 61st block.
  task automatic test_reset_row_length();
    for (int i = 0; i < FillDepth; i++) send_item(act_item(12'(i), rand_act()));
    repeat (60) send_item(weight_item(rand_weights(), 8'($urandom)));
    write_row_len(9'd61);
    send_item(weight_item(rand_weights(), 8'($urandom)));
    wait_idle();
  endtask

  // Field extremes, every weight code and the scale corner cases, one block per row.
  task automatic test_field_extremes();
    write_row_len(9'd1);
    for (int i = 0; i < 8; i++) send_item(act_item(12'(i), 16'h8000));
    for (int i = 8; i < 16; i++) send_item(act_item(12'(i), 16'h7FFF));
    send_item(weight_item(64'h7777_7777_7777_7777, 8'h7F));
    send_item(weight_item(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF));
    send_item(weight_item(64'hFEDC_BA98_7654_3210, 8'h38));
    send_item(weight_item(64'h8888_8888_8888_8888, 8'h7F));
    send_item(weight_item(64'h7777_7777_7777_7777, 8'h80));
    send_item(weight_item(64'h7777_7777_7777_7777, 8'h00));
    send_item(weight_item(64'h7777_7777_7777_7777, 8'h01));
    send_item(weight_item(64'h0123_4567_89AB_CDEF, 8'h87));
    send_item(weight_item(64'hFFFF_FFFF_0000_0000, 8'h08));
    wait_idle();
  endtask

  // Row length code 0 acts as 1; codes 511 and 256 must keep a row open for FillBlocks - 1
  // blocks, which then ends when the length is shortened.
  task automatic test_row_length_limits();
    write_row_len(9'd0);
    repeat (3) send_item(weight_item(rand_weights(), 8'($urandom)));
    write_row_len(9'd511);
    repeat (FillBlocks - 1) send_item(weight_item(rand_weights(), 8'($urandom)));
    write_row_len(9'(FillBlocks));
    send_item(weight_item(rand_weights(), 8'($urandom)));
    write_row_len(9'd256);
    repeat (FillBlocks - 1) send_item(weight_item(64'h7777_7777_7777_7777, 8'h7F));
    write_row_len(9'd1);
    send_item(weight_item(64'h7777_7777_7777_7777, 8'h7F));
    wait_idle();
  endtask

  // Shortening the row while a row is open ends it at the next block.
  task automatic test_mid_row_change();
    write_row_len(9'd8);
    repeat (5) send_item(weight_item(rand_weights(), 8'($urandom)));
    write_row_len(9'd3);
    repeat (4) send_item(weight_item(rand_weights(), 8'($urandom)));
    wait_idle();
  endtask

  // Random phases, each with its own row length; mostly weight blocks.
  task automatic test_random_traffic();
    int start_count;
    logic [8:0] len;
    start_count = items_sent;
    while (items_sent - start_count < RandomItems) begin
      case ($urandom_range(0, 19))
        0: len = 9'd0;
        1: len = 9'(FillBlocks);
        2: len = 9'($urandom_range(41, FillBlocks - 1));
        3, 4: len = 9'($urandom_range(9, 40));
        default: len = 9'($urandom_range(1, 8));
      endcase
      write_row_len(len);
      repeat ($urandom_range(20, 120)) begin
        if ($urandom_range(0, 4) == 0)
          send_item(act_item(12'($urandom), rand_act()));
        else
          send_item(weight_item(rand_weights(), 8'($urandom)));
      end
    end
    wait_idle();
  endtask

  // Receiver stall pattern: always ready, random, or mostly stalled.
  logic [1:0] stall_mode;
  int stall_cnt;
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= 2'($urandom_range(0, 2));
      stall_cnt <= $urandom_range(16, 96);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compares each accepted result with the oldest predicted row.
  always @(posedge clk) begin
    fbsg_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected row: row_sum %0d row_number %0d",
               $signed(out_item.row_sum), out_item.row_number);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (out_item.row_sum !== want.row_sum) begin
          $error("row_sum: expected %0d, got %0d", $signed(want.row_sum),
                 $signed(out_item.row_sum));
          errors++;
        end
        if (out_item.row_number !== want.row_number) begin
          $error("row_number: expected %0d, got %0d", want.row_number,
                 out_item.row_number);
          errors++;
        end
      end
    end
  end

  // Ends the run if no handshake completes for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stall_mode = 2'd0;
    stall_cnt = 0;
    idle_cycles = 0;
    errors = 0;
    items_sent = 0;
    rows_checked = 0;
    burst_left = 0;
    blk_pos = 0;
    row_acc = 0;
    rows_done = 16'd0;
    row_len_reg = 9'd160;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 9'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_row_length();
    test_field_extremes();
    test_row_length_limits();
    test_mid_row_change();
    test_random_traffic();
    $display("Sent %0d items and checked %0d row sums across row lengths 0 to 511.",
             items_sent, rows_checked);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fbsg_pkg.sv
rtl/core/fbsg_ram.sv
rtl/core/fbsg_mac.sv
rtl/core/fp4_block_scaled_gemv_top.sv
dv/testbench.sv
